### hdl/windowed_mean_ring_queue_macros.svh
// ----------------------------------------------------------------------------
// windowed_mean_ring_queue_macros.svh
// Assertion macros shared by the checker of the windowed mean ring queue.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MEAN_RING_QUEUE_MACROS_SVH
`define WINDOWED_MEAN_RING_QUEUE_MACROS_SVH

// Same-cycle implication, off while in reset
`define WMRQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wmrq check failed");

// Next-cycle implication, off while in reset
`define WMRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wmrq check failed");

`endif

### hdl/wmrq_pkg.sv
// ----------------------------------------------------------------------------
// wmrq_pkg
// Field widths and shared types of the windowed mean ring queue.
// ----------------------------------------------------------------------------
package wmrq_pkg;

	localparam int VALUE_W = 16;
	localparam int TAG_W   = 32;
	localparam int MEAN_W  = 16;
	localparam int FILL_W  = 3;

	// Status of the serial divider as seen by the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hdl/wmrq_store.sv
// ----------------------------------------------------------------------------
// wmrq_store
// Ring store of values and tags with slot pointers, fill count and running
// total; reports the tag of the entry dropped on a push into a full ring.
// ----------------------------------------------------------------------------
module wmrq_store import wmrq_pkg::*; #(
	parameter int WINDOW = 5,
	parameter int CNT_W  = 3,
	parameter int SUM_W  = 19
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [VALUE_W-1:0] sample_value,
	input  logic [TAG_W-1:0]   item_tag,
	output logic [SUM_W-1:0]   total,
	output logic [CNT_W-1:0]   count,
	output logic               evicted,
	output logic [TAG_W-1:0]   evicted_tag
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);

	logic [VALUE_W-1:0] value_mem [WINDOW];
	logic [TAG_W-1:0]   tag_mem [WINDOW];

	logic [SLOT_W-1:0] oldest_q, next_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  total_q;
	logic              evicted_q;
	logic [TAG_W-1:0]  evt_tag_q;
	logic              full;
	logic [SLOT_W-1:0] oldest_adv, next_adv;

	assign full       = (count_q == FULL_CNT);
	assign oldest_adv = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
	assign next_adv   = (next_q == LAST_SLOT) ? '0 : next_q + 1'b1;

	// Write the new entry at the head slot
	always_ff @(posedge clk) begin
		if (push) begin
			value_mem[next_q] <= sample_value;
			tag_mem[next_q]   <= item_tag;
		end
	end

	// Advance pointers, drop the oldest entry when full, update the total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			next_q    <= '0;
			count_q   <= '0;
			total_q   <= '0;
			evicted_q <= 1'b0;
			evt_tag_q <= '0;
		end else if (push) begin
			next_q    <= next_adv;
			evicted_q <= full;
			if (full) begin
				oldest_q  <= oldest_adv;
				evt_tag_q <= tag_mem[oldest_q];
				total_q   <= total_q + SUM_W'(sample_value) - SUM_W'(value_mem[oldest_q]);
			end else begin
				count_q   <= count_q + 1'b1;
				evt_tag_q <= '0;
				total_q   <= total_q + SUM_W'(sample_value);
			end
		end
	end

	assign total       = total_q;
	assign count       = count_q;
	assign evicted     = evicted_q;
	assign evicted_tag = evt_tag_q;

endmodule

### hdl/wmrq_div.sv
// ----------------------------------------------------------------------------
// wmrq_div
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the same register that the quotient shifts into.
// ----------------------------------------------------------------------------
module wmrq_div import wmrq_pkg::*; #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output div_stat_t        stat
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  shift_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [DEN_W:0]    trial, diff;
	logic              ge;

	// Bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, shift_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			shift_q <= num;
			den_q   <= den;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[NUM_W-2:0], ge};
			rem_q   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// Count the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo       = shift_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/windowed_mean_ring_queue.sv
// ----------------------------------------------------------------------------
// windowed_mean_ring_queue
// Sliding window of up to WINDOW samples with a rounded-half-up mean.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_value and item_tag, taken when sample_valid is
//   high and sample_stall is low. Each request pushes one entry; on a full
//   window the oldest entry is dropped first and its tag comes back.
//   Result channel: window_mean, evicted_valid, evicted_tag and fill_level,
//   taken when result_valid is high and result_stall is low. Every request
//   gives exactly one result.
//   The dividend is NUM_W = 17 + clog2(WINDOW + 1) bits wide (20 for a
//   window of five). Requests are paced by the bit-serial divider, which
//   retires one quotient bit a cycle; a new request is taken only once the
//   last result has reached the output register.
//   A finished result waits in the output register; the next request is
//   taken meanwhile. If the receiver stalls for longer than one division,
//   the following result waits in the divider and sample_stall stays high.
//   Reset empties the window and clears result_valid; no clearing pass.
// ----------------------------------------------------------------------------
module windowed_mean_ring_queue import wmrq_pkg::*; #(
	parameter int WINDOW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [VALUE_W-1:0] sample_value,
	input  logic [TAG_W-1:0]   item_tag,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [MEAN_W-1:0]  window_mean,
	output logic               evicted_valid,
	output logic [TAG_W-1:0]   evicted_tag,
	output logic [FILL_W-1:0]  fill_level
);

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = VALUE_W + CNT_W;
	localparam int NUM_W = SUM_W + 1;
	localparam int DEN_W = CNT_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WAIT
	} state_t;

	state_t            state_q;
	logic              start_q;
	logic              result_valid_q;
	logic [MEAN_W-1:0] mean_q;
	logic              evicted_q;
	logic [TAG_W-1:0]  evt_tag_q;
	logic [FILL_W-1:0] fill_q;

	logic              push;
	logic [SUM_W-1:0]  total;
	logic [CNT_W-1:0]  count;
	logic              st_evicted;
	logic [TAG_W-1:0]  st_evt_tag;
	logic [NUM_W-1:0]  num, quo;
	logic [DEN_W-1:0]  den;
	div_stat_t         div_stat;
	logic              out_free;

	assign sample_stall = (state_q != S_IDLE);
	assign push         = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;

	wmrq_store #(
		.WINDOW (WINDOW),
		.CNT_W  (CNT_W),
		.SUM_W  (SUM_W)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.sample_value (sample_value),
		.item_tag     (item_tag),
		.total        (total),
		.count        (count),
		.evicted      (st_evicted),
		.evicted_tag  (st_evt_tag)
	);

	// Rounded mean as (2*sum + count) / (2*count)
	assign num = {total, 1'b0} + NUM_W'(count);
	assign den = {count, 1'b0};

	wmrq_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (num),
		.den    (den),
		.quo    (quo),
		.stat   (div_stat)
	);

	// Sequence one request and hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			start_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (push) begin
						start_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.busy) begin
						start_q <= 1'b0;
					end
					if (div_stat.done) begin
						if (out_free) begin
							result_valid_q <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					start_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Load the result payload as the request completes
	always_ff @(posedge clk) begin
		if (((state_q == S_DIV && div_stat.done) || state_q == S_WAIT) && out_free) begin
			mean_q    <= quo[MEAN_W-1:0];
			evicted_q <= st_evicted;
			evt_tag_q <= st_evt_tag;
			fill_q    <= FILL_W'(count);
		end
	end

	assign result_valid  = result_valid_q;
	assign window_mean   = mean_q;
	assign evicted_valid = evicted_q;
	assign evicted_tag   = evt_tag_q;
	assign fill_level    = fill_q;

endmodule

### hdl/wmrq_checker.sv
// ----------------------------------------------------------------------------
// wmrq_checker
// Port-level checks of the windowed mean ring queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_mean_ring_queue_macros.svh"

module wmrq_checker import wmrq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic [MEAN_W-1:0]  window_mean,
	input logic               evicted_valid,
	input logic [TAG_W-1:0]   evicted_tag,
	input logic [FILL_W-1:0]  fill_level
);

	// A taken request blocks the next one while it is worked on
	`WMRQ_ASSERT_NEXT(a_busy_after_req, clk, arst_n, sample_valid && !sample_stall, sample_stall)

	// A result never reports an empty window
	`WMRQ_ASSERT_IMPLY(a_fill_nonzero, clk, arst_n, result_valid, fill_level != '0)

	// No drop, no tag
	`WMRQ_ASSERT_IMPLY(a_tag_zero, clk, arst_n, result_valid && !evicted_valid, evicted_tag == '0)

	// A stalled result holds
	`WMRQ_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(window_mean) && $stable(evicted_tag) && $stable(fill_level))

endmodule

bind windowed_mean_ring_queue wmrq_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_valid  (sample_valid),
	.sample_stall  (sample_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.window_mean   (window_mean),
	.evicted_valid (evicted_valid),
	.evicted_tag   (evicted_tag),
	.fill_level    (fill_level)
);
